// ----- rtl/hafr_pkg.sv -----
// ----------------------------------------------------------------------------
// hafr_pkg
// shared types, constants and helpers of the hex ascii frame receiver
// ----------------------------------------------------------------------------
package hafr_pkg;

  // framing bytes
  localparam logic [7:0] PREAMBLE_BYTE = 8'hff;
  localparam logic [7:0] OPENING_BYTE  = 8'h10;
  localparam logic [7:0] CLOSING_BYTE  = 8'h11;

  // ascii to nibble offsets
  localparam logic [7:0] ALPHA_FIRST   = 8'h41;
  localparam logic [7:0] ALPHA_OFFSET  = 8'h37;
  localparam logic [7:0] DIGIT_OFFSET  = 8'h30;

  // frame limits
  localparam int unsigned MAX_DATA_BYTES    = 64;
  localparam int unsigned MIN_FRAME_LENGTH  = 8;
  localparam int unsigned MAX_FRAME_LENGTH  = 136;
  localparam int unsigned STORED_DATA_BYTES = 32;
  localparam int unsigned FRAME_OVERHEAD    = 8;

  // queue depths
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  // configuration registers
  localparam int unsigned NUM_CFG = 8;
  localparam int unsigned CFG_IW  = 3;
  localparam logic [CFG_IW-1:0] CFG_ADDR_A = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ADDR_B = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ADDR_C = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CMD_A  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_CMD_B  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_CMD_C  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_CMD_D  = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_CMD_E  = 3'd7;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_START,
    PH_ADDR,
    PH_CMD,
    PH_COUNT,
    PH_CHARS,
    PH_STOP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LONG      = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_BAD_CMD   = 3'd4,
    ST_OVER_MAX  = 3'd5,
    ST_BAD_CHECK = 3'd6
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // work item handed from the parser to the evaluator
  typedef struct packed {
    kind_t      kind;
    logic [7:0] lo_char;
    logic [7:0] hi_char;
    logic [7:0] index;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] count;
    logic [7:0] sum;
  } op_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] count;
    status_t    status;
  } result_t;

  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    nibble_of = (c >= ALPHA_FIRST) ? (c - ALPHA_OFFSET) : (c - DIGIT_OFFSET);
  endfunction

  // stray upper bits of the low nibble value pass into the byte
  function automatic logic [7:0] pair_to_byte(input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] h;
    logic [7:0] l;
    h = nibble_of(hi);
    l = nibble_of(lo);
    pair_to_byte = {h[3:0], 4'h0} | l;
  endfunction

endpackage

// ----- rtl/hafr_fifo.sv -----
// ----------------------------------------------------------------------------
// hafr_fifo
// small synchronous queue with full and empty flags
// ----------------------------------------------------------------------------
module hafr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/hafr_front.sv -----
// ----------------------------------------------------------------------------
// hafr_front
// frame parser: hunts for the header, tracks characters, builds work items
// ----------------------------------------------------------------------------
module hafr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  input  logic [7:0]    rx_byte,
  output logic          op_push,
  output hafr_pkg::op_t op
);

  import hafr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] addr_r, cmd_r, count_r, sum_r, lo_r, chk_hi_r;
  logic [8:0] pos_r;
  logic [8:0] ndata;
  logic       in_data, in_check_lo, data_pair, stored;

  assign ndata       = {count_r, 1'b0};
  assign in_data     = (pos_r < ndata);
  assign in_check_lo = (pos_r == ndata);
  assign data_pair   = in_data & pos_r[0];
  assign stored      = ({1'b0, pos_r[8:1]} < 9'(STORED_DATA_BYTES));

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (byte_valid) begin
      unique case (phase_r)
        PH_HUNT:  if (rx_byte == PREAMBLE_BYTE) phase_nxt = PH_START;
        PH_START: phase_nxt = (rx_byte == OPENING_BYTE) ? PH_ADDR : PH_HUNT;
        PH_ADDR:  phase_nxt = PH_CMD;
        PH_CMD:   phase_nxt = PH_COUNT;
        PH_COUNT: phase_nxt = PH_CHARS;
        PH_CHARS: if (pos_r == ndata + 9'd1) phase_nxt = PH_STOP;
        PH_STOP:  phase_nxt = PH_HUNT;
        default:  phase_nxt = PH_HUNT;
      endcase
    end
  end

  // work item output
  always_comb begin
    op_push    = 1'b0;
    op.kind    = KIND_DATA;
    op.lo_char = lo_r;
    op.hi_char = rx_byte;
    op.index   = pos_r[8:1];
    op.address = addr_r;
    op.command = cmd_r;
    op.count   = count_r;
    op.sum     = sum_r;
    if (byte_valid) begin
      unique case (phase_r)
        PH_CHARS: op_push = data_pair & stored;
        PH_STOP: begin
          op_push    = (rx_byte == CLOSING_BYTE);
          op.kind    = KIND_STATUS;
          op.hi_char = chk_hi_r;
        end
        default: op_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // header and character bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      cmd_r    <= '0;
      count_r  <= '0;
      sum_r    <= '0;
      lo_r     <= '0;
      chk_hi_r <= '0;
      pos_r    <= '0;
    end else if (byte_valid) begin
      unique case (phase_r)
        PH_ADDR: begin
          addr_r <= rx_byte;
          sum_r  <= rx_byte;
        end
        PH_CMD: begin
          cmd_r <= rx_byte;
          sum_r <= sum_r + rx_byte;
        end
        PH_COUNT: begin
          count_r <= rx_byte;
          sum_r   <= sum_r + rx_byte;
          pos_r   <= '0;
        end
        PH_CHARS: begin
          pos_r <= pos_r + 9'd1;
          if (in_data) begin
            sum_r <= sum_r + rx_byte;
            if (!pos_r[0]) begin
              lo_r <= rx_byte;
            end
          end else if (in_check_lo) begin
            lo_r <= rx_byte;
          end else begin
            chk_hi_r <= rx_byte;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/hafr_back.sv -----
// ----------------------------------------------------------------------------
// hafr_back
// evaluator: decodes data pairs, checks the frame at its stop byte
// ----------------------------------------------------------------------------
module hafr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hafr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [7:0]                    cfg_data,
  input  hafr_pkg::op_t                 op,
  output hafr_pkg::result_t             res
);

  import hafr_pkg::*;

  logic [7:0] cfg_r [NUM_CFG];
  logic [7:0] decoded;
  logic [7:0] expect_sum;
  logic [9:0] frame_len;
  logic       addr_ok, cmd_ok;
  status_t    st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  assign decoded    = pair_to_byte(op.lo_char, op.hi_char);
  assign expect_sum = 8'd0 - op.sum;
  assign frame_len  = 10'(FRAME_OVERHEAD) + {1'b0, op.count, 1'b0};
  assign addr_ok    = (op.address == cfg_r[CFG_ADDR_A]) || (op.address == cfg_r[CFG_ADDR_B])
                   || (op.address == cfg_r[CFG_ADDR_C]);
  assign cmd_ok     = (op.command == cfg_r[CFG_CMD_A]) || (op.command == cfg_r[CFG_CMD_B])
                   || (op.command == cfg_r[CFG_CMD_C]) || (op.command == cfg_r[CFG_CMD_D])
                   || (op.command == cfg_r[CFG_CMD_E]);

  // first failing check wins
  always_comb begin
    priority if (frame_len < 10'(MIN_FRAME_LENGTH)) begin
      st = ST_SHORT;
    end else if (frame_len > 10'(MAX_FRAME_LENGTH)) begin
      st = ST_LONG;
    end else if (!addr_ok) begin
      st = ST_BAD_ADDR;
    end else if (!cmd_ok) begin
      st = ST_BAD_CMD;
    end else if ({1'b0, op.count} > 9'(MAX_DATA_BYTES)) begin
      st = ST_OVER_MAX;
    end else if (decoded != expect_sum) begin
      st = ST_BAD_CHECK;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    res.kind    = op.kind;
    res.address = op.address;
    res.command = op.command;
    res.count   = op.count;
    if (op.kind == KIND_STATUS) begin
      res.data_byte  = '0;
      res.data_index = '0;
      res.status     = st;
    end else begin
      res.data_byte  = decoded;
      res.data_index = op.index;
      res.status     = ST_OK;
    end
  end

endmodule

// ----- rtl/hex_ascii_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// hex_ascii_frame_receiver
// byte-serial frame receiver for ascii-hex encoded frames
// ----------------------------------------------------------------------------
// usage
//   input channel: push a received byte on in_rx_byte with in_push; the
//   beat is taken when in_full is low; one per cycle if out_pop keeps up.
//   result channel: while out_empty is low the oldest result sits on the
//   out_ ports; out_pop takes it. a data result comes for each decoded data
//   byte below the stored limit, a status result at each good stop byte.
//   framing errors drop the frame with no result, the parser hunts again.
//   path: the edge that takes a byte writes its work item into the work
//   queue; the result enters the result queue when that item is popped.
//   throughput: one byte per cycle while out_pop keeps up; both queues
//   are two entries deep by default.
//   stall: if out_pop stays low the result queue fills, then the work
//   queue, and in_full rises; nothing is lost.
//   configuration: cfg_wr_en writes cfg_data into register cfg_index
//   (addresses a..c, then commands a..e); write only while idle.
//   reset: rst_n low clears the queues, the parser (hunting) and the
//   configuration registers to zero.
// ----------------------------------------------------------------------------
module hex_ascii_frame_receiver #(
  parameter int unsigned MID_DEPTH = hafr_pkg::MID_DEPTH,
  parameter int unsigned OUT_DEPTH = hafr_pkg::OUT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [7:0]                  in_rx_byte,
  // result channel
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_kind,
  output logic [7:0]                  out_data_byte,
  output logic [7:0]                  out_data_index,
  output logic [7:0]                  out_frame_address,
  output logic [7:0]                  out_frame_command,
  output logic [7:0]                  out_frame_count,
  output logic [2:0]                  out_status,
  // configuration port
  input  logic                        cfg_wr_en,
  input  logic [hafr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [7:0]                  cfg_data
);

  import hafr_pkg::*;

  logic    byte_valid;
  logic    op_push, mid_full, mid_empty, mid_pop;
  op_t     op_in, op_head;
  result_t res, res_head;
  logic    out_full;

  // a beat is taken whenever the work queue has room
  assign in_full    = mid_full;
  assign byte_valid = in_push & ~mid_full;

  // parser
  hafr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .rx_byte    (in_rx_byte),
    .op_push    (op_push),
    .op         (op_in)
  );

  // work queue between parser and evaluator
  hafr_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .wdata (op_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (op_head),
    .empty (mid_empty)
  );

  // evaluator works on the queue head whenever the result queue has room
  assign mid_pop = ~mid_empty & ~out_full;

  hafr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op_head),
    .res       (res)
  );

  // result queue, registered toward the consumer
  hafr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_pop),
    .wdata (res),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_kind          = res_head.kind;
  assign out_data_byte     = res_head.data_byte;
  assign out_data_index    = res_head.data_index;
  assign out_frame_address = res_head.address;
  assign out_frame_command = res_head.command;
  assign out_frame_count   = res_head.count;
  assign out_status        = res_head.status;

endmodule
